@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// No dependencies; every macro samples on clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bda_pkg.sv @@
// Shared types and codes of the banker deadlock-avoidance unit.
// No dependencies; used by the lanes, the top level and the checker.
`default_nettype none
package bda_pkg;

  localparam int AMT_W    = 8;
  localparam int IO_RES   = 4;
  localparam int NUM_REGS = 4;

  // Item kinds.
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CLAIM   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_LIMIT  = 2'd1;
  localparam logic [1:0] STAT_UNSAFE = 2'd2;
  localparam logic [1:0] STAT_CLAIM  = 2'd3;

  // Register index of total_units_r0; the others follow in order.
  localparam logic [1:0] REG_TOTAL_R0 = 2'd0;

  // Operation broadcast to every resource lane.
  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_GRANT,
    LOP_UNDO,
    LOP_RELEASE,
    LOP_CLAIM,
    LOP_SCAN_INIT,
    LOP_SCAN_ADD
  } lane_op_t;

  // Comparison results reported by one lane.
  typedef struct packed {
    logic over_need;
    logic short_avail;
    logic short_held;
    logic below_held;
    logic fits;
  } lane_flags_t;

endpackage
`default_nettype wire

@@ hw/rtl/bda_if.sv @@
// Channel interfaces of the banker unit: item, result and configuration.
// Depends on nothing but plain logic types.
`default_nettype none
interface bda_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] thread;
  logic [7:0] amount_r0;
  logic [7:0] amount_r1;
  logic [7:0] amount_r2;
  logic [7:0] amount_r3;
  modport source (output valid, kind, thread, amount_r0, amount_r1, amount_r2, amount_r3,
                  input ready);
  modport sink (input valid, kind, thread, amount_r0, amount_r1, amount_r2, amount_r3,
                output ready);
endinterface

interface bda_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] over_need_mask;
  logic [3:0] short_mask;
  logic [7:0] avail_r0;
  logic [7:0] avail_r1;
  logic [7:0] avail_r2;
  logic [7:0] avail_r3;
  modport source (output valid, status, over_need_mask, short_mask,
                  avail_r0, avail_r1, avail_r2, avail_r3, input ready);
  modport sink (input valid, status, over_need_mask, short_mask,
                avail_r0, avail_r1, avail_r2, avail_r3, output ready);
endinterface

interface bda_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bda_lane.sv @@
// One resource lane: available count, need and held columns, and safety work sum.
// Depends on bda_pkg for the lane operation and flag types.
`default_nettype none
module bda_lane import bda_pkg::*; #(
  parameter int THREADS    = 8,
  parameter int COUNT_BITS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [AMT_W-1:0]              cfg_val,
  input  wire lane_op_t                op,
  input  wire [$clog2(THREADS)-1:0]    tidx,
  input  wire [$clog2(THREADS)-1:0]    sidx,
  input  wire [AMT_W-1:0]              amount,
  output lane_flags_t                  flags,
  output logic [COUNT_BITS-1:0]        avail
);

  localparam int CW = (COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W;
  localparam int WW = COUNT_BITS + $clog2(THREADS + 1) + 1;
  localparam logic [CW:0] CMAX = (CW + 1)'((1 << COUNT_BITS) - 1);

  logic [COUNT_BITS-1:0] need [THREADS];
  logic [COUNT_BITS-1:0] held [THREADS];
  logic [WW-1:0]         work;

  logic [CW:0] amt_x, need_x, held_x, avail_x, sum_x, amt_sat, cfg_sat;

  // Operands widened to a common width for the compares.
  always_comb begin
    amt_x   = (CW + 1)'(amount);
    need_x  = (CW + 1)'(need[tidx]);
    held_x  = (CW + 1)'(held[tidx]);
    avail_x = (CW + 1)'(avail);
    sum_x   = avail_x + amt_x;
    amt_sat = (amt_x > CMAX) ? CMAX : amt_x;
    cfg_sat = ((CW + 1)'(cfg_val) > CMAX) ? CMAX : (CW + 1)'(cfg_val);
  end

  assign flags.over_need   = amt_x > need_x;
  assign flags.short_avail = amt_x > avail_x;
  assign flags.short_held  = amt_x > held_x;
  assign flags.below_held  = amt_sat < held_x;
  assign flags.fits        = work >= WW'(need[sidx]);

  // State updates for the broadcast operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
      work  <= '0;
      for (int t = 0; t < THREADS; t++) begin
        need[t] <= '0;
        held[t] <= '0;
      end
    end else begin
      if (cfg_we) begin
        avail <= COUNT_BITS'(cfg_sat);
      end
      case (op)
        LOP_GRANT: begin
          avail      <= avail - COUNT_BITS'(amt_x);
          held[tidx] <= held[tidx] + COUNT_BITS'(amt_x);
          need[tidx] <= need[tidx] - COUNT_BITS'(amt_x);
        end
        LOP_UNDO: begin
          avail      <= avail + COUNT_BITS'(amt_x);
          held[tidx] <= held[tidx] - COUNT_BITS'(amt_x);
          need[tidx] <= need[tidx] + COUNT_BITS'(amt_x);
        end
        LOP_RELEASE: begin
          avail      <= (sum_x > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(sum_x);
          held[tidx] <= held[tidx] - COUNT_BITS'(amt_x);
          need[tidx] <= need[tidx] + COUNT_BITS'(amt_x);
        end
        LOP_CLAIM: begin
          need[tidx] <= COUNT_BITS'(amt_sat - held_x);
        end
        LOP_SCAN_INIT: begin
          work <= WW'(avail);
        end
        LOP_SCAN_ADD: begin
          work <= work + WW'(held[sidx]);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/banker_deadlock_avoidance_unit.sv @@
// Banker deadlock-avoidance unit: resource lanes, merge of their flags and control.
// Depends on bda_pkg, the bda_if interfaces and bda_lane.
//
// Usage. Items (request, release, set claim) arrive on in_ch, one result per
// item leaves on out_ch; both use valid/ready and move one beat per handshake.
// cfg_ch writes total_units_r0..r3 (index 0..3), each loading the available
// count of its resource; it is always ready, and the user must write it only
// while idle (the block itself does not enforce this). Release, claim and
// refused items go from acceptance to S_DONE and then into the output
// register. A request that passes the limit check runs the safety check in
// S_INIT and then S_SCAN, one thread per cycle over up to THREADS passes,
// before S_DONE. One item is in work at a time; the next is taken as soon
// as the previous result sits in the output register, even if the receiver
// has not yet taken it. A stalled receiver holds the result and blocks only
// the finish of the following item. Reset (rst, synchronous) clears
// available counts, both tables and the output valid flag; no clearing pass
// is needed.
`default_nettype none
module banker_deadlock_avoidance_unit import bda_pkg::*; #(
  parameter int THREADS    = 8,
  parameter int RESOURCES  = 4,
  parameter int COUNT_BITS = 8
) (
  input  wire     clk,
  input  wire     rst,
  bda_item_if.sink     in_ch,
  bda_result_if.source out_ch,
  bda_cfg_if.sink      cfg_ch
);

  localparam int TW = $clog2(THREADS);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_SCAN, S_DONE} state_t;

  state_t          state;
  logic [TW-1:0]   thr;
  logic [AMT_W-1:0] amt [IO_RES];
  logic [TW-1:0]   scan_t;
  logic [TW-1:0]   pass;
  logic            prog;
  logic [THREADS-1:0] fin;
  logic [1:0]      pend_status;
  logic [3:0]      pend_over;
  logic [3:0]      pend_short;

  logic            out_valid;
  logic [1:0]      out_status;
  logic [3:0]      out_over;
  logic [3:0]      out_short;
  logic [AMT_W-1:0] out_avail [IO_RES];

  logic [AMT_W-1:0] in_amt [IO_RES];
  logic            in_fire;
  logic            bad;
  logic [TW-1:0]   tidx;
  lane_op_t        lop;
  lane_flags_t     lflags [RESOURCES];
  logic [COUNT_BITS-1:0] lavail [RESOURCES];
  logic [3:0]      over_m, short_req_m, short_rel_m, below_m;
  logic            fits_all;
  logic            hit;
  logic [THREADS-1:0] fin_next;
  logic            last_t;
  logic            unsafe_end;
  logic            safe_end;

  assign in_amt[0] = in_ch.amount_r0;
  assign in_amt[1] = in_ch.amount_r1;
  assign in_amt[2] = in_ch.amount_r2;
  assign in_amt[3] = in_ch.amount_r3;

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign bad = (in_ch.kind != KIND_REQUEST && in_ch.kind != KIND_RELEASE &&
                in_ch.kind != KIND_CLAIM) || (32'(in_ch.thread) >= THREADS);
  assign tidx = (state == S_IDLE) ? TW'(in_ch.thread) : thr;

  // Resource lanes.
  for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
    logic [AMT_W-1:0] lane_amt;
    logic             lane_cfg;
    if (r < IO_RES) begin : g_io
      assign lane_amt = (state == S_IDLE) ? in_amt[r] : amt[r];
      assign lane_cfg = cfg_ch.valid && (cfg_ch.index == REG_TOTAL_R0 + 2'(r));
    end else begin : g_pad
      assign lane_amt = '0;
      assign lane_cfg = 1'b0;
    end
    bda_lane #(.THREADS(THREADS), .COUNT_BITS(COUNT_BITS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .cfg_we  (lane_cfg),
      .cfg_val (cfg_ch.data),
      .op      (lop),
      .tidx    (tidx),
      .sidx    (scan_t),
      .amount  (lane_amt),
      .flags   (lflags[r]),
      .avail   (lavail[r])
    );
  end

  // Merge of the lane flags.
  always_comb begin
    over_m      = '0;
    short_req_m = '0;
    short_rel_m = '0;
    below_m     = '0;
    fits_all    = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (r < IO_RES) begin
        over_m[r]      = lflags[r].over_need;
        short_req_m[r] = lflags[r].short_avail;
        short_rel_m[r] = lflags[r].short_held;
        below_m[r]     = lflags[r].below_held;
      end
      fits_all = fits_all & lflags[r].fits;
    end
  end

  // Safety scan step for the current thread.
  always_comb begin
    hit        = !fin[scan_t] && fits_all;
    fin_next   = fin;
    fin_next[scan_t] = fin[scan_t] | hit;
    last_t     = (scan_t == TW'(THREADS - 1));
    safe_end   = last_t && (&fin_next);
    unsafe_end = last_t && !(&fin_next) && (!(prog | hit) || pass == TW'(THREADS - 1));
  end

  // Lane operation for this cycle.
  always_comb begin
    lop = LOP_NONE;
    case (state)
      S_IDLE: begin
        if (in_fire && !bad) begin
          if (in_ch.kind == KIND_REQUEST && over_m == '0 && short_req_m == '0) begin
            lop = LOP_GRANT;
          end else if (in_ch.kind == KIND_RELEASE && short_rel_m == '0) begin
            lop = LOP_RELEASE;
          end else if (in_ch.kind == KIND_CLAIM && below_m == '0) begin
            lop = LOP_CLAIM;
          end
        end
      end
      S_INIT: lop = LOP_SCAN_INIT;
      S_SCAN: begin
        if (unsafe_end) begin
          lop = LOP_UNDO;
        end else if (hit) begin
          lop = LOP_SCAN_ADD;
        end
      end
      default: lop = LOP_NONE;
    endcase
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fin       <= '0;
      prog      <= 1'b0;
      pass      <= '0;
      scan_t    <= '0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            thr <= tidx;
            for (int r = 0; r < IO_RES; r++) begin
              amt[r] <= in_amt[r];
            end
            pend_status <= STAT_OK;
            pend_over   <= '0;
            pend_short  <= '0;
            state       <= S_DONE;
            if (bad) begin
              pend_status <= STAT_LIMIT;
            end else if (in_ch.kind == KIND_REQUEST) begin
              if (over_m != '0 || short_req_m != '0) begin
                pend_status <= STAT_LIMIT;
                pend_over   <= over_m;
                pend_short  <= short_req_m;
              end else begin
                state <= S_INIT;
              end
            end else if (in_ch.kind == KIND_RELEASE) begin
              if (short_rel_m != '0) begin
                pend_status <= STAT_LIMIT;
                pend_short  <= short_rel_m;
              end
            end else if (below_m != '0) begin
              pend_status <= STAT_CLAIM;
              pend_over   <= below_m;
            end
          end
        end
        S_INIT: begin
          fin    <= '0;
          prog   <= 1'b0;
          pass   <= '0;
          scan_t <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          fin <= fin_next;
          if (safe_end) begin
            state <= S_DONE;
          end else if (unsafe_end) begin
            pend_status <= STAT_UNSAFE;
            state       <= S_DONE;
          end else if (last_t) begin
            scan_t <= '0;
            pass   <= pass + 1'b1;
            prog   <= 1'b0;
          end else begin
            scan_t <= scan_t + 1'b1;
            prog   <= prog | hit;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= pend_status;
            out_over   <= pend_over;
            out_short  <= pend_short;
            for (int r = 0; r < IO_RES; r++) begin
              out_avail[r] <= (r < RESOURCES) ? AMT_W'(lavail[r]) : '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.over_need_mask = out_over;
  assign out_ch.short_mask     = out_short;
  assign out_ch.avail_r0       = out_avail[0];
  assign out_ch.avail_r1       = out_avail[1];
  assign out_ch.avail_r2       = out_avail[2];
  assign out_ch.avail_r3       = out_avail[3];

endmodule
`default_nettype wire

@@ hw/rtl/bda_checker.sv @@
// Port-level checks of the banker unit, bound to the top level.
// Depends on bda_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bda_checker import bda_pkg::*; (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] status,
  input wire [3:0] over_need_mask,
  input wire [3:0] short_mask
);

  // A result beat that is not taken stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // The unit works on one item at a time.
  `ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "item taken while busy")

  // Granted and unsafe results carry no mask bits.
  `ASSERT_SAME(a_masks_clear, out_valid && (status == STAT_OK || status == STAT_UNSAFE),
               over_need_mask == 4'd0 && short_mask == 4'd0, "mask set on clean result")

  // A claim refusal names at least one resource and no shortage.
  `ASSERT_SAME(a_claim_mask, out_valid && status == STAT_CLAIM,
               over_need_mask != 4'd0 && short_mask == 4'd0, "bad claim refusal masks")

endmodule

bind banker_deadlock_avoidance_unit bda_checker u_bda_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .over_need_mask (out_ch.over_need_mask),
  .short_mask     (out_ch.short_mask)
);
`default_nettype wire
